// ----- rtl/lts_pkg.sv -----
`timescale 1ns / 1ps

package lts_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int STAMP_BITS = 32;
  localparam int LEN_BITS   = 17;
  localparam int SLOT_BITS  = $clog2(ENTRIES);
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);

  // stamp minimum is taken in two registered levels: groups of four, then across groups
  localparam int GROUP_SIZE = 4;
  localparam int GROUPS     = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic select;
    logic commit;
  } cmd_t;

endpackage

// ----- rtl/lts_req_if.sv -----
`timescale 1ns / 1ps

interface lts_req_if;
  logic          valid;
  logic          ready;
  logic          action;
  lts_pkg::key_t key;
  lts_pkg::len_t object_length;

  modport source (output valid, output action, output key, output object_length,
                  input ready);
  modport sink   (input valid, input action, input key, input object_length,
                  output ready);
endinterface

// ----- rtl/lts_rsp_if.sv -----
`timescale 1ns / 1ps

interface lts_rsp_if;
  logic           valid;
  logic           ready;
  logic           hit;
  lts_pkg::slot_t slot;
  lts_pkg::len_t  stored_length;
  logic           replaced;

  modport source (output valid, output hit, output slot, output stored_length,
                  output replaced, input ready);
  modport sink   (input valid, input hit, input slot, input stored_length,
                  input replaced, output ready);
endinterface

// ----- rtl/lts_ctrl.sv -----
`timescale 1ns / 1ps

module lts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lts_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = ST_SEL;
      end
      ST_SEL: begin
        cmd.select = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CMP))
    else $error("accepted transaction did not start compare");

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit would overwrite a pending result");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");
`endif

endmodule

// ----- rtl/lts_datapath.sv -----
`timescale 1ns / 1ps

module lts_datapath (
  input  logic            clk,
  input  logic            rst,
  input  lts_pkg::cmd_t   cmd,
  input  logic            in_action,
  input  lts_pkg::key_t   in_key,
  input  lts_pkg::len_t   in_length,
  output logic            out_hit,
  output lts_pkg::slot_t  out_slot,
  output lts_pkg::len_t   out_length,
  output logic            out_replaced
);

  lts_pkg::key_t   entry_keys    [lts_pkg::ENTRIES];
  lts_pkg::len_t   entry_lengths [lts_pkg::ENTRIES];
  lts_pkg::stamp_t entry_stamps  [lts_pkg::ENTRIES];

  lts_pkg::count_t filled_count;
  lts_pkg::stamp_t stamp_counter;

  logic            req_action;
  lts_pkg::key_t   req_key;
  lts_pkg::len_t   req_length;

  logic [lts_pkg::ENTRIES-1:0] match;
  lts_pkg::stamp_t grp_stamp [lts_pkg::GROUPS];
  lts_pkg::slot_t  grp_slot  [lts_pkg::GROUPS];

  logic            hit;
  lts_pkg::slot_t  hit_slot;
  lts_pkg::slot_t  victim;

  logic [lts_pkg::ENTRIES-1:0] match_next;
  lts_pkg::stamp_t grp_stamp_next [lts_pkg::GROUPS];
  lts_pkg::slot_t  grp_slot_next  [lts_pkg::GROUPS];
  lts_pkg::slot_t  hit_slot_next;
  lts_pkg::slot_t  victim_next;
  lts_pkg::stamp_t best_stamp;

  logic            full;
  lts_pkg::slot_t  wr_slot;
  logic            do_write;

  assign full = (filled_count == lts_pkg::count_t'(lts_pkg::ENTRIES));

  // compare against filled slots only; first-level stamp minimum per group
  always_comb begin
    for (int i = 0; i < lts_pkg::ENTRIES; i++) begin
      match_next[i] = (lts_pkg::count_t'(i) < filled_count) && (entry_keys[i] == req_key);
    end
    for (int g = 0; g < lts_pkg::GROUPS; g++) begin
      grp_stamp_next[g] = entry_stamps[g * lts_pkg::GROUP_SIZE];
      grp_slot_next[g]  = lts_pkg::slot_t'(g * lts_pkg::GROUP_SIZE);
      for (int m = 1; m < lts_pkg::GROUP_SIZE; m++) begin
        if ((g * lts_pkg::GROUP_SIZE + m < lts_pkg::ENTRIES) &&
            (entry_stamps[g * lts_pkg::GROUP_SIZE + m] < grp_stamp_next[g])) begin
          grp_stamp_next[g] = entry_stamps[g * lts_pkg::GROUP_SIZE + m];
          grp_slot_next[g]  = lts_pkg::slot_t'(g * lts_pkg::GROUP_SIZE + m);
        end
      end
    end
  end

  // lowest matching slot; oldest group winner, ties to the lower slot
  always_comb begin
    hit_slot_next = '0;
    for (int i = lts_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot_next = lts_pkg::slot_t'(i);
      end
    end
    best_stamp  = grp_stamp[0];
    victim_next = grp_slot[0];
    for (int g = 1; g < lts_pkg::GROUPS; g++) begin
      if (grp_stamp[g] < best_stamp) begin
        best_stamp  = grp_stamp[g];
        victim_next = grp_slot[g];
      end
    end
  end

  always_comb begin
    if (req_action == lts_pkg::ACT_INSERT) begin
      wr_slot = full ? victim : filled_count[lts_pkg::SLOT_BITS-1:0];
    end else begin
      wr_slot = hit_slot;
    end
    do_write = cmd.commit && (req_action == lts_pkg::ACT_INSERT);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= in_action;
      req_key    <= in_key;
      req_length <= in_length;
    end
    if (cmd.compare) begin
      match     <= match_next;
      grp_stamp <= grp_stamp_next;
      grp_slot  <= grp_slot_next;
    end
    if (cmd.select) begin
      hit      <= |match;
      hit_slot <= hit_slot_next;
      victim   <= victim_next;
    end
    if (do_write) begin
      entry_keys[wr_slot]    <= req_key;
      entry_lengths[wr_slot] <= req_length;
    end
    if (cmd.commit && (do_write || hit)) begin
      entry_stamps[wr_slot] <= stamp_counter;
    end
    if (cmd.commit) begin
      if (req_action == lts_pkg::ACT_INSERT) begin
        out_hit      <= 1'b0;
        out_slot     <= wr_slot;
        out_length   <= req_length;
        out_replaced <= full;
      end else begin
        out_hit      <= hit;
        out_slot     <= hit ? hit_slot : '0;
        out_length   <= hit ? entry_lengths[hit_slot] : '0;
        out_replaced <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count  <= '0;
      stamp_counter <= '0;
    end else if (cmd.commit) begin
      // a lookup miss leaves the counter alone
      if (do_write || hit) begin
        stamp_counter <= stamp_counter + 1'b1;
      end
      if (do_write && !full) begin
        filled_count <= filled_count + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lru_tag_store.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload                                  Transfer
// req      in   action, key, object_length               valid && ready
// rsp      out  hit, slot, stored_length, replaced       valid && ready
//
// Each transaction steps through accept, key compare with group stamp minimum,
// final select and update; the compare and minimum registers make these separate steps.
// Reset clears the fill count, stamp counter, control state and output valid; entries need no clearing.
// The update cycle stalls while the previous result still sits in the output
// register; a new request is accepted while a finished result waits.
module lru_tag_store (
  input  logic       clk,
  input  logic       rst,
  lts_req_if.sink    req,
  lts_rsp_if.source  rsp
);

  lts_pkg::cmd_t cmd;

  lts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lts_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_action    (req.action),
    .in_key       (req.key),
    .in_length    (req.object_length),
    .out_hit      (rsp.hit),
    .out_slot     (rsp.slot),
    .out_length   (rsp.stored_length),
    .out_replaced (rsp.replaced)
  );

endmodule
